// ===== hdl/apu_rle_pkg.sv =====
package apu_rle_pkg;

    localparam int WAVE_BYTES = 16;
    localparam int WAVE_AW    = $clog2(WAVE_BYTES);
    localparam int CNT_W      = 24;
    localparam logic [CNT_W-1:0] CNT_MAX = 24'hFFFFFF;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [15:0] WAVE_BASE = 16'hFF30;

    // one classified item handed from the front to the back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] cycles;
        logic        is_wave;
    } t_item;

    // result fields
    typedef struct packed {
        logic [10:0] sq2_freq_code;
        logic [1:0]  sq2_duty;
        logic [3:0]  sq2_level;
        logic        sq2_active;
        logic [10:0] sq1_freq_code;
        logic [1:0]  sq1_duty;
        logic [3:0]  sq1_level;
        logic        sq1_active;
        logic        bad_address;
        logic [7:0]  read_data;
    } t_result;

    localparam int ITEM_W = $bits(t_item);

    // 4b init*3b step/3b period; init if period 0; rising: init minus it
    function automatic logic [3:0] env_level(input logic [3:0] init, input logic [2:0] step,
                                             input logic [2:0] period, input logic rising);
        logic [6:0] prod;
        logic [6:0] q;
        logic [6:0] v;
        prod = 7'({3'd0, init} * {4'd0, step});
        q    = 7'd0;
        unique case (period)
            3'd0: q = {3'd0, init};
            3'd1: q = prod;
            3'd2: q = prod >> 1;
            3'd3: q = 7'((16'(prod) * 16'd43) >> 7);
            3'd4: q = prod >> 2;
            3'd5: q = 7'((16'(prod) * 16'd205) >> 10);
            3'd6: q = 7'((16'(prod) * 16'd171) >> 10);
            3'd7: q = 7'((16'(prod) * 16'd293) >> 11);
            default: q = 7'd0;
        endcase
        v = q;
        if (rising)
            v = (q > {3'd0, init}) ? 7'd0 : 7'({3'd0, init} - q);
        return (v > 7'd15) ? 4'hF : v[3:0];
    endfunction

endpackage

// ===== hdl/apu_rle_ram.sv =====
module apu_rle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/apu_rle_front.sv =====
module apu_rle_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [15:0]          i_addr,
    input  logic [7:0]           i_data,
    input  logic [15:0]          i_cycles,
    output logic                 o_valid,
    input  logic                 i_ready,
    output apu_rle_pkg::t_item   o_item
);
    // two-entry queue
    apu_rle_pkg::t_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_push, w_pop;
    apu_rle_pkg::t_item w_in;

    always_comb begin
        w_in.cmd     = i_cmd;
        w_in.addr    = i_addr;
        w_in.data    = i_data;
        w_in.cycles  = i_cycles;
        w_in.is_wave = (i_addr >= apu_rle_pkg::WAVE_BASE) &&
                       (17'(i_addr) < 17'(apu_rle_pkg::WAVE_BASE) + 17'(apu_rle_pkg::WAVE_BYTES));
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_in;
                r_wr      <= ~r_wr;
            end
            if (w_pop)
                r_rd <= ~r_rd;
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
    end
endmodule

// ===== hdl/apu_rle_back.sv =====
module apu_rle_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  apu_rle_pkg::t_item    i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output apu_rle_pkg::t_result  o_res
);
    localparam int CW = apu_rle_pkg::CNT_W;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_TICK = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    apu_rle_pkg::t_item r_it;
    logic [1:0] r_ch;
    logic       r_ev0, r_ev1;
    logic       r_early1;
    logic       r_stop1_early;

    logic [6:0]  r_sweep;
    logic [1:0]  r_duty [2];
    logic [7:0]  r_len_set [4];
    logic [3:0]  r_env_init [4];
    logic        r_env_rise [4];
    logic [2:0]  r_env_per [4];
    logic [10:0] r_freq [4];
    logic [3:0]  r_noise;
    logic        r_len_en [4];
    logic        r_on [4];
    logic [CW-1:0] r_len_cnt [4];
    logic [CW-1:0] r_env_cnt [4];
    logic [2:0]  r_env_step [4];
    logic        r_wave_en;
    logic [2:0]  r_mvol [2];
    logic [7:0]  r_term;
    logic        r_sound_on;
    logic [3:0]  r_level [2];
    logic [7:0]  r_rd;
    logic        r_bad;
    logic        r_wave_rd;
    logic        r_wave_vld [apu_rle_pkg::WAVE_BYTES];

    // channel of a frequency-high register
    function automatic logic [1:0] freq_ch(input logic [15:0] a);
        logic [1:0] c;
        c = 2'd2;
        if (a == 16'hFF14) c = 2'd0;
        else if (a == 16'hFF19) c = 2'd1;
        return c;
    endfunction

    // channel of an envelope register
    function automatic logic [1:0] env_ch(input logic [15:0] a);
        logic [1:0] c;
        c = 2'd3;
        if (a == 16'hFF12) c = 2'd0;
        else if (a == 16'hFF17) c = 2'd1;
        return c;
    endfunction

    logic [7:0] w_wave_q;
    logic       w_wave_we;
    apu_rle_ram #(.WIDTH(8), .DEPTH(apu_rle_pkg::WAVE_BYTES)) u_wave (
        .i_clk  (i_clk),
        .i_we   (w_wave_we),
        .i_waddr(r_it.addr[apu_rle_pkg::WAVE_AW-1:0]),
        .i_wdata(r_it.data),
        .i_raddr(r_it.addr[apu_rle_pkg::WAVE_AW-1:0]),
        .o_rdata(w_wave_q)
    );
    assign w_wave_we = (r_state == S_EXEC) && r_it.is_wave && (r_it.cmd == apu_rle_pkg::CMD_WRITE);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_res.read_data     = r_wave_rd ? w_wave_q : r_rd;
        o_res.bad_address   = r_bad;
        o_res.sq1_active    = r_on[0];
        o_res.sq1_level     = r_level[0];
        o_res.sq1_duty      = r_duty[0];
        o_res.sq1_freq_code = r_freq[0];
        o_res.sq2_active    = r_on[1];
        o_res.sq2_level     = r_level[1];
        o_res.sq2_duty      = r_duty[1];
        o_res.sq2_freq_code = r_freq[1];
    end

    // tick arithmetic for the channel in r_ch
    logic [CW:0]   w_lsum, w_esum;
    logic [CW-1:0] w_lsat, w_esat;
    logic [CW-1:0] w_span;
    logic          w_step;
    always_comb begin
        w_lsum = {1'b0, r_len_cnt[r_ch]} + (CW+1)'(r_it.cycles);
        w_esum = {1'b0, r_env_cnt[r_ch]} + (CW+1)'(r_it.cycles);
        w_lsat = (w_lsum > {1'b0, apu_rle_pkg::CNT_MAX}) ? apu_rle_pkg::CNT_MAX : w_lsum[CW-1:0];
        w_esat = (w_esum > {1'b0, apu_rle_pkg::CNT_MAX}) ? apu_rle_pkg::CNT_MAX : w_esum[CW-1:0];
        w_span = {5'd0, r_env_per[r_ch], 16'd0};
        w_step = (r_env_per[r_ch] != 3'd0) && (r_env_step[r_ch] != 3'd0) && (w_esat > w_span);
    end

    // square stop test and level
    logic       w_stop [2];
    logic [3:0] w_lvl [2];
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_stop[c] = !r_sound_on || (r_len_en[c] &&
                ({3'd0, 7'(7'd64 - {1'b0, r_len_set[c][5:0]}), 14'd0} < r_len_cnt[c]));
            w_lvl[c]  = apu_rle_pkg::env_level(r_env_init[c], r_env_step[c],
                                               r_env_per[c], r_env_rise[c]);
        end
    end

    logic [3:0] w_envb [4];
    always_comb begin
        for (int c = 0; c < 4; c++)
            w_envb[c] = r_env_init[c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sweep    <= '0;
            r_noise    <= '0;
            r_wave_en  <= 1'b0;
            r_term     <= '0;
            r_sound_on <= 1'b0;
            r_ch       <= '0;
            r_ev0      <= 1'b0;
            r_ev1      <= 1'b0;
            r_early1   <= 1'b0;
            r_stop1_early <= 1'b0;
            r_wave_rd  <= 1'b0;
            r_rd       <= '0;
            r_bad      <= 1'b0;
            for (int c = 0; c < apu_rle_pkg::WAVE_BYTES; c++)
                r_wave_vld[c] <= 1'b0;
            for (int c = 0; c < 4; c++) begin
                r_len_set[c]  <= '0;
                r_env_init[c] <= '0;
                r_env_rise[c] <= 1'b0;
                r_env_per[c]  <= '0;
                r_freq[c]     <= '0;
                r_len_en[c]   <= 1'b0;
                r_on[c]       <= 1'b0;
                r_len_cnt[c]  <= '0;
                r_env_cnt[c]  <= '0;
                r_env_step[c] <= '0;
            end
            for (int c = 0; c < 2; c++) begin
                r_duty[c]  <= '0;
                r_mvol[c]  <= '0;
                r_level[c] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_it    <= i_item;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rd      <= 8'd0;
                    r_bad     <= 1'b0;
                    r_wave_rd <= 1'b0;
                    r_ev0     <= 1'b0;
                    r_ev1     <= 1'b0;
                    r_early1  <= 1'b0;
                    r_ch      <= 2'd0;
                    r_state   <= S_EVAL;
                    if (r_it.cmd == apu_rle_pkg::CMD_READ) begin
                        unique case (r_it.addr)
                            16'hFF10: r_rd <= {1'b0, r_sweep};
                            16'hFF11: r_rd <= {r_duty[0], 6'd0};
                            16'hFF12: r_rd <= {w_envb[0], r_env_rise[0], r_env_per[0]};
                            16'hFF13, 16'hFF18, 16'hFF1D: r_rd <= 8'd0;
                            16'hFF14: r_rd <= {1'b0, r_len_en[0], 6'd0};
                            16'hFF16: r_rd <= {r_duty[1], 6'd0};
                            16'hFF17: r_rd <= {w_envb[1], r_env_rise[1], r_env_per[1]};
                            16'hFF19: r_rd <= {1'b0, r_len_en[1], 6'd0};
                            16'hFF1A: r_rd <= {r_wave_en, 7'd0};
                            16'hFF1B: r_rd <= r_len_set[2];
                            16'hFF1C: r_rd <= {r_env_init[2][2:0], 5'd0};
                            16'hFF1E: r_rd <= {1'b0, r_len_en[2], 6'd0};
                            16'hFF20: r_rd <= r_len_set[3];
                            16'hFF21: r_rd <= {w_envb[3], r_env_rise[3], r_env_per[3]};
                            16'hFF22: r_rd <= {r_freq[3][3:0], r_noise};
                            16'hFF23: r_rd <= {1'b0, r_len_en[3], 6'd0};
                            16'hFF24: r_rd <= {1'b0, r_mvol[1], 1'b0, r_mvol[0]};
                            16'hFF25: r_rd <= r_term;
                            16'hFF26: r_rd <= {r_sound_on, 3'd0, r_on[3], r_on[2], r_on[1], r_on[0]};
                            default: begin
                                // never-written wave bytes read as zero
                                if (r_it.is_wave)
                                    r_wave_rd <= r_wave_vld[r_it.addr[apu_rle_pkg::WAVE_AW-1:0]];
                                else r_bad <= 1'b1;
                            end
                        endcase
                    end else if (r_it.cmd == apu_rle_pkg::CMD_WRITE) begin
                        unique case (r_it.addr)
                            16'hFF10: begin r_sweep <= r_it.data[6:0]; r_ev0 <= 1'b1; end
                            16'hFF11, 16'hFF16: begin
                                r_duty[r_it.addr[2]]                <= r_it.data[7:6];
                                r_len_set[{1'b0, r_it.addr[2]}]     <= {2'd0, r_it.data[5:0]};
                                r_ev0 <= !r_it.addr[2];
                                r_ev1 <= r_it.addr[2];
                            end
                            16'hFF12, 16'hFF17, 16'hFF21: begin
                                r_env_init[env_ch(r_it.addr)] <= r_it.data[7:4];
                                r_env_rise[env_ch(r_it.addr)] <= r_it.data[3];
                                r_env_per[env_ch(r_it.addr)]  <= r_it.data[2:0];
                                r_env_step[env_ch(r_it.addr)] <= r_it.data[2:0];
                                r_env_cnt[env_ch(r_it.addr)]  <= '0;
                                r_ev0 <= (r_it.addr == 16'hFF12);
                                r_ev1 <= (r_it.addr == 16'hFF17);
                            end
                            16'hFF13: begin r_freq[0][7:0] <= r_it.data; r_ev0 <= 1'b1; end
                            16'hFF18: begin r_freq[1][7:0] <= r_it.data; r_ev1 <= 1'b1; end
                            16'hFF1D: r_freq[2][7:0] <= r_it.data;
                            16'hFF14, 16'hFF19, 16'hFF1E: begin
                                r_freq[freq_ch(r_it.addr)][10:8] <= r_it.data[2:0];
                                r_len_en[freq_ch(r_it.addr)]     <= r_it.data[6];
                                if (r_it.data[7]) begin
                                    r_len_cnt[freq_ch(r_it.addr)] <= '0;
                                    r_on[freq_ch(r_it.addr)]      <= 1'b1;
                                end
                                r_ev0 <= (r_it.addr == 16'hFF14);
                                r_ev1 <= (r_it.addr == 16'hFF19);
                            end
                            16'hFF1A: r_wave_en <= r_it.data[7];
                            16'hFF1B: r_len_set[2] <= r_it.data;
                            16'hFF1C: begin
                                r_env_init[2] <= {2'd0, r_it.data[6:5]};
                                r_env_cnt[2]  <= '0;
                                r_env_step[2] <= r_env_per[2];
                            end
                            16'hFF20: r_len_set[3] <= {2'd0, r_it.data[5:0]};
                            16'hFF22: begin
                                r_freq[3] <= {7'd0, r_it.data[7:4]};
                                r_noise   <= r_it.data[3:0];
                            end
                            16'hFF23: begin
                                r_len_en[3] <= r_it.data[6];
                                if (r_it.data[7]) begin
                                    r_len_cnt[3] <= '0;
                                    r_on[3]      <= 1'b1;
                                end
                            end
                            16'hFF24: begin
                                r_mvol[1] <= r_it.data[6:4];
                                r_mvol[0] <= r_it.data[2:0];
                                r_ev0 <= 1'b1; r_ev1 <= 1'b1;
                            end
                            16'hFF25: begin r_term <= r_it.data; r_ev0 <= 1'b1; r_ev1 <= 1'b1; end
                            16'hFF26: begin
                                r_sound_on <= r_it.data[7];
                                if (!r_it.data[7]) begin
                                    // sound off clears the register fields once
                                    r_sweep   <= '0;
                                    r_noise   <= '0;
                                    r_wave_en <= 1'b0;
                                    r_term    <= '0;
                                    for (int c = 0; c < 4; c++) begin
                                        r_len_set[c]  <= '0;
                                        r_env_init[c] <= '0;
                                        r_env_rise[c] <= 1'b0;
                                        r_env_per[c]  <= '0;
                                        r_env_step[c] <= '0;
                                        r_env_cnt[c]  <= '0;
                                        r_freq[c]     <= '0;
                                        r_len_en[c]   <= 1'b0;
                                    end
                                    for (int c = 0; c < 2; c++) begin
                                        r_duty[c] <= '0;
                                        r_mvol[c] <= '0;
                                    end
                                end
                                r_ev0 <= 1'b1; r_ev1 <= 1'b1;
                            end
                            16'hFF15, 16'hFF1F: ;
                            default: begin
                                if (!r_it.is_wave) r_bad <= 1'b1;
                                else r_wave_vld[r_it.addr[apu_rle_pkg::WAVE_AW-1:0]] <= 1'b1;
                            end
                        endcase
                    end else if (r_it.cmd == apu_rle_pkg::CMD_TICK) begin
                        r_state <= S_TICK;
                    end
                end
                S_TICK: begin
                    // one channel per cycle
                    r_len_cnt[r_ch] <= w_lsat;
                    r_env_cnt[r_ch] <= w_step ? (w_esat - w_span) : w_esat;
                    if (w_step) begin
                        r_env_step[r_ch] <= r_env_step[r_ch] - 3'd1;
                        r_ev0 <= 1'b1;
                        r_ev1 <= 1'b1;
                        // a step of channel 0 alone judges square 2 on its old length count
                        r_early1 <= (r_ch == 2'd0);
                        if (r_ch == 2'd0)
                            r_stop1_early <= w_stop[1];
                    end
                    r_ch <= r_ch + 2'd1;
                    if (r_ch == 2'd3)
                        r_state <= S_EVAL;
                end
                S_EVAL: begin
                    for (int c = 0; c < 2; c++) begin
                        if ((c == 0) ? r_ev0 : r_ev1) begin
                            if ((c == 1 && r_early1) ? r_stop1_early : w_stop[c]) begin
                                r_on[c]    <= 1'b0;
                                r_level[c] <= 4'd0;
                            end else begin
                                r_level[c] <= w_lvl[c];
                            end
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/apu_register_length_envelope.sv =====
// channel  dir  tdata fields (low bit up)                         tuser
// s_axis   in   command, address, write_data, tick_cycles (42b)   -
// m_axis   out  read_data, bad_address, sq1 active/level/duty/freq,
//               sq2 active/level/duty/freq (45b, 3 fill bits)     -
// the back runs exec, eval and output (held until m_axis_tready) per item; a tick
// item adds the tick state, one channel per cycle through the shared counter adder
// reset is synchronous active low and clears all fields, counters and wave ram valid state
// a two-entry transfer queue lets the input side take up to two more
// transfers while a result waits on m_axis_tready
module apu_register_length_envelope (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // command, address, write_data, tick_cycles
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // read_data, bad_address, sq1..., sq2..., zeros
);
    logic               w_qv, w_qr;
    apu_rle_pkg::t_item w_item;
    apu_rle_pkg::t_result w_res;

    apu_rle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tdata[1:0]),
        .i_addr  (s_axis_tdata[17:2]),
        .i_data  (s_axis_tdata[25:18]),
        .i_cycles(s_axis_tdata[41:26]),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_item  (w_item)
    );

    apu_rle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qv),
        .o_ready (w_qr),
        .i_item  (w_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    // result fields packed from bit 0, three zero fill bits on top
    assign m_axis_tdata = {3'd0, w_res};
endmodule
